FILE: rtl/gdfs_pkg.sv
// ----------------------------------------------------------------------------
// gdfs_pkg
// Shared widths, codes and defaults for the depth-first traversal block.
// ----------------------------------------------------------------------------
package gdfs_pkg;

  // fixed field widths
  localparam int KIND_W = 2;
  localparam int VTX_W  = 4;
  localparam int NV_W   = 5;

  // default vertex capacity
  localparam int MAX_VERTICES_DEF = 16;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WALK  = 2'd2;

  // register indexes (paddr[2])
  localparam logic REG_NUM_VERTICES = 1'b0;
  localparam logic REG_UNDIRECTED   = 1'b1;

  // register reset values
  localparam logic [NV_W-1:0] NUM_VERTICES_RST = 5'd16;
  localparam logic            UNDIRECTED_RST   = 1'b1;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

endpackage

FILE: rtl/gdfs_in_if.sv
// ----------------------------------------------------------------------------
// gdfs_in_if
// Command channel: one beat is a clear, an edge insert or a traversal start.
// ----------------------------------------------------------------------------
interface gdfs_in_if import gdfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [VTX_W-1:0]  vertex_a;
  logic [VTX_W-1:0]  vertex_b;

  modport source (output valid, output kind, output vertex_a, output vertex_b,
                  input ready);
  modport sink   (input valid, input kind, input vertex_a, input vertex_b,
                  output ready);
endinterface

FILE: rtl/gdfs_out_if.sv
// ----------------------------------------------------------------------------
// gdfs_out_if
// Result channel: one beat per visited vertex or per command acknowledge.
// ----------------------------------------------------------------------------
interface gdfs_out_if import gdfs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VTX_W-1:0] visited_vertex;
  logic             last;
  logic             status;

  modport source (output valid, output visited_vertex, output last, output status,
                  input ready);
  modport sink   (input valid, input visited_vertex, input last, input status,
                  output ready);
endinterface

FILE: rtl/graph_dfs_stack_traversal.sv
// ----------------------------------------------------------------------------
// graph_dfs_stack_traversal
// Depth-first walk over a bit adjacency matrix held in a synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   items   : command beats (kind, vertex_a, vertex_b); taken one at a time,
//             ready is high only while no command is in progress.
//   results : clear and edge commands give one beat (last = 1); a traversal
//             gives one beat per visited vertex in visiting order, the final
//             one with last = 1. A bad vertex gives a single beat, status 1.
//   APB     : num_vertices at 0x0, undirected_mode at 0x4; write only when idle.
// Steps:
//   clear / bad vertex : straight to S_DONE and the result register
//   edge insert        : row read, modify, write (row a, then row b when undirected)
//   traversal          : per visited vertex, a stack pop, a row memory read and a
//                        row scan of one neighbour per cycle
// A finished beat waits in the output register; the next command is taken
// meanwhile, and the block stalls only when it has a new beat to load.
// Reset clears the row valid bits (matrix reads as empty), the stack pointer
// and the registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module graph_dfs_stack_traversal import gdfs_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  gdfs_in_if.sink            items,
  gdfs_out_if.source         results,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int SW = $clog2(MAX_VERTICES + 1);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int LW = (NW > NV_W) ? NW : NV_W;

  typedef enum logic [3:0] {
    S_IDLE, S_EDGE_A, S_EDGE_B, S_DONE, S_POP, S_ROW, S_ROWW, S_SCAN, S_EMIT
  } state_t;

  state_t state;

  // configuration registers
  logic [NV_W-1:0] num_vertices;
  logic            undirected_mode;

  // command registers
  logic [VW-1:0]   a_q;
  logic [VW-1:0]   b_q;
  logic            res_status;

  // walk state
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] row;
  logic [SW-1:0]           sp;
  logic [LW-1:0]           v;

  // adjacency memory and row valid bits
  logic [MAX_VERTICES-1:0] row_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] row_q;
  logic                    row_hit_q;
  logic                    row_re;
  logic [VW-1:0]           row_ra;
  logic                    row_we;
  logic [VW-1:0]           row_wa;
  logic [MAX_VERTICES-1:0] row_wd;
  logic [MAX_VERTICES-1:0] row_cur;

  // stack memory
  logic [VW-1:0] stk_mem [MAX_VERTICES];
  logic [VW-1:0] stk_q;
  logic          stk_re;
  logic [VW-1:0] stk_ra;
  logic          stk_we;
  logic [VW-1:0] stk_wa;
  logic [VW-1:0] stk_wd;

  // output register
  logic             out_valid;
  logic [VTX_W-1:0] out_vertex;
  logic             out_last;
  logic             out_status;

  logic            in_fire;
  logic            out_free;
  logic            out_load;
  logic [LW-1:0]   lim;
  logic [LW-1:0]   a_ext;
  logic [LW-1:0]   b_ext;
  logic            a_ok;
  logic            b_ok;
  logic [VW-1:0]   vi;
  logic            push;
  logic [SW-1:0]   sp_m1;
  logic            cfg_we;

  // handshake and helpers
  assign items.ready = (state == S_IDLE);
  assign in_fire     = items.valid && items.ready;
  assign out_free    = !out_valid || results.ready;
  assign out_load    = out_free && ((state == S_DONE) || (state == S_EMIT));

  assign results.valid          = out_valid;
  assign results.visited_vertex = out_vertex;
  assign results.last           = out_last;
  assign results.status         = out_status;

  assign lim   = (LW'(num_vertices) > LW'(MAX_VERTICES)) ? LW'(MAX_VERTICES)
                                                         : LW'(num_vertices);
  assign a_ext = LW'(items.vertex_a);
  assign b_ext = LW'(items.vertex_b);
  assign a_ok  = a_ext < lim;
  assign b_ok  = b_ext < lim;
  assign vi    = v[VW-1:0];
  assign sp_m1 = sp - SW'(1);
  assign push  = (state == S_SCAN) && (v < lim) && row[vi] && !visited[vi];

  assign row_cur = row_hit_q ? row_q : '0;

  // memory port control
  always_comb begin
    row_re = 1'b0;
    row_ra = a_ext[VW-1:0];
    row_we = 1'b0;
    row_wa = a_q;
    row_wd = row_cur | (MAX_VERTICES'(1) << b_q);
    stk_re = 1'b0;
    stk_ra = sp_m1[VW-1:0];
    stk_we = 1'b0;
    stk_wa = sp[VW-1:0];
    stk_wd = vi;
    unique case (state)
      S_IDLE: begin
        row_re = in_fire && (items.kind == KIND_EDGE);
        stk_we = in_fire && (items.kind == KIND_WALK) && a_ok;
        stk_wa = '0;
        stk_wd = a_ext[VW-1:0];
      end
      S_EDGE_A: begin
        row_we = 1'b1;
        row_re = undirected_mode;
        row_ra = b_q;
      end
      S_EDGE_B: begin
        row_we = 1'b1;
        row_wa = b_q;
        row_wd = row_cur | (MAX_VERTICES'(1) << a_q);
      end
      S_POP: begin
        stk_re = 1'b1;
      end
      S_ROW: begin
        row_re = 1'b1;
        row_ra = stk_q;
      end
      S_SCAN: begin
        stk_we = push;
      end
      default: begin
      end
    endcase
  end

  // adjacency memory
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    if (row_re) begin
      row_q     <= row_mem[row_ra];
      row_hit_q <= row_valid[row_ra];
    end
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_q <= stk_mem[stk_ra];
    end
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_NUM_VERTICES: prdata = PDATA_W'(num_vertices);
      REG_UNDIRECTED:   prdata = PDATA_W'(undirected_mode);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices    <= NUM_VERTICES_RST;
      undirected_mode <= UNDIRECTED_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_NUM_VERTICES: num_vertices    <= pwdata[NV_W-1:0];
        REG_UNDIRECTED:   undirected_mode <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // command sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      row_valid <= '0;
      visited   <= '0;
      sp        <= '0;
    end else begin
      // a new beat loads over a drained one
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            a_q <= a_ext[VW-1:0];
            b_q <= b_ext[VW-1:0];
            unique case (items.kind)
              KIND_CLEAR: begin
                row_valid  <= '0;
                res_status <= STATUS_OK;
                state      <= S_DONE;
              end
              KIND_EDGE: begin
                if (a_ok && b_ok) begin
                  res_status <= STATUS_OK;
                  state      <= S_EDGE_A;
                end else begin
                  res_status <= STATUS_BAD;
                  state      <= S_DONE;
                end
              end
              KIND_WALK: begin
                if (a_ok) begin
                  visited <= MAX_VERTICES'(1) << a_ext[VW-1:0];
                  sp      <= SW'(1);
                  state   <= S_POP;
                end else begin
                  res_status <= STATUS_BAD;
                  state      <= S_DONE;
                end
              end
              default: begin
                res_status <= STATUS_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_EDGE_A: begin
          row_valid[a_q] <= 1'b1;
          state          <= undirected_mode ? S_EDGE_B : S_DONE;
        end
        S_EDGE_B: begin
          row_valid[b_q] <= 1'b1;
          state          <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_vertex <= '0;
            out_last   <= 1'b1;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        S_POP: begin
          sp    <= sp_m1;
          state <= S_ROW;
        end
        S_ROW: begin
          state <= S_ROWW;
        end
        S_ROWW: begin
          row   <= row_cur;
          v     <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (v < lim) begin
            if (push) begin
              visited[vi] <= 1'b1;
              sp          <= sp + SW'(1);
            end
            v <= v + LW'(1);
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_vertex <= VTX_W'(stk_q);
            out_last   <= (sp == '0);
            out_status <= STATUS_OK;
            state      <= (sp == '0) ? S_IDLE : S_POP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // stack never holds more entries than vertices marked
  a_stack_vs_marks: assert property (@(posedge clk) disable iff (rst)
    $countones(visited) >= int'(sp))
    else $error("stack deeper than visited set");

  // stack depth bounded by capacity
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SW'(MAX_VERTICES))
    else $error("stack overflow");

  // a pushed vertex was not yet visited and is marked next cycle
  a_push_marks: assert property (@(posedge clk) disable iff (rst)
    push |=> visited[$past(vi)])
    else $error("pushed vertex not marked");

  // scan counter stays within the vertex count
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (v <= lim))
    else $error("scan ran past vertex count");

  // the beat marked last ends the traversal
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && out_free && (sp == '0)) |=> (state == S_IDLE) && out_last)
    else $error("walk continued after last beat");
`endif

endmodule
